@@ hdl/ktl_pkg.sv @@
// Shared types, codes and token classification for the keyword token lexer.
package ktl_pkg;

    localparam int KW_MAX_LEN = 8;
    localparam int KW_NUM     = 19;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [KW_MAX_LEN-1:0][7:0] t_kw_prefix;

    typedef struct packed {
        logic [4:0] kind;
        logic [5:0] length;
        logic       last;
    } t_result;

    localparam logic [4:0] K_LPAREN   = 5'd18;
    localparam logic [4:0] K_RPAREN   = 5'd19;
    localparam logic [4:0] K_LBRACE   = 5'd20;
    localparam logic [4:0] K_RBRACE   = 5'd21;
    localparam logic [4:0] K_LBRACKET = 5'd22;
    localparam logic [4:0] K_RBRACKET = 5'd23;
    localparam logic [4:0] K_ASSIGN   = 5'd24;
    localparam logic [4:0] K_SPACE    = 5'd26;
    localparam logic [4:0] K_TAB      = 5'd27;
    localparam logic [4:0] K_NEWLINE  = 5'd28;
    localparam logic [4:0] K_COMMENT  = 5'd29;
    localparam logic [4:0] K_LITERAL  = 5'd30;
    localparam logic [4:0] K_IDENT    = 5'd31;

    localparam logic [7:0] CH_TILDE = "~";
    localparam logic [7:0] CH_QUOTE = "\"";

    // keyword text sits right-aligned: first character in the highest used byte
    localparam logic [63:0] KW_TEXT [KW_NUM] = '{
        "include", "byte", "char", "int", "prec", "bool", "true", "false",
        "string", "function", "returns", "return", "while", "still", "do",
        "loop", "for", "static", "end"
    };
    localparam int KW_LEN [KW_NUM] = '{
        7, 4, 4, 3, 4, 4, 4, 5, 6, 8, 7, 6, 5, 5, 2, 4, 3, 6, 3
    };
    localparam logic [4:0] KW_KIND [KW_NUM] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd25
    };

    function automatic logic is_next_ender(input logic [7:0] c);
        return c inside {"{", "}", "[", "]", "(", ")", ",", " ", "^", "\n"};
    endfunction

    function automatic logic is_cur_ender(input logic [7:0] c);
        return is_next_ender(c) || (c inside {"+", "-", "*", "/"});
    endfunction

    function automatic logic [4:0] classify(input t_kw_prefix pfx, input logic [7:0] cnt,
                                            input logic saw_tilde, input logic saw_quote);
        logic [4:0] kind;
        logic       found;
        logic       same;
        kind  = K_IDENT;
        found = 1'b0;
        if (cnt == 8'd1) begin
            found = 1'b1;
            case (pfx[0])
                "(":     kind = K_LPAREN;
                ")":     kind = K_RPAREN;
                "{":     kind = K_LBRACE;
                "}":     kind = K_RBRACE;
                "[":     kind = K_LBRACKET;
                "]":     kind = K_RBRACKET;
                "=":     kind = K_ASSIGN;
                " ":     kind = K_SPACE;
                "\t":    kind = K_TAB;
                "\n":    kind = K_NEWLINE;
                default: found = 1'b0;
            endcase
        end
        // first match in table order wins
        for (int i = KW_NUM - 1; i >= 0; i--) begin
            same = (32'(cnt) == KW_LEN[i]);
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                if (j < KW_LEN[i]) begin
                    same = same && (pfx[j] == KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]);
                end
            end
            if (same && !found) begin
                kind = KW_KIND[i];
            end
        end
        if (!found) begin
            found = 1'b0;
            for (int i = 0; i < KW_NUM; i++) begin
                same = (32'(cnt) == KW_LEN[i]);
                for (int j = 0; j < KW_MAX_LEN; j++) begin
                    if (j < KW_LEN[i]) begin
                        same = same && (pfx[j] == KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]);
                    end
                end
                found = found || same;
            end
            if (!found) begin
                if (saw_tilde) begin
                    kind = K_COMMENT;
                end else if (saw_quote) begin
                    kind = K_LITERAL;
                end else begin
                    kind = K_IDENT;
                end
            end
        end
        return kind;
    endfunction

endpackage

@@ hdl/ktl_fifo.sv @@
// Result queue with up to two in-order writes and one read per cycle.
module ktl_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_wr_cnt,
    input  ktl_pkg::t_result  i_wr_data0,
    input  ktl_pkg::t_result  i_wr_data1,
    input  logic              i_rd,
    output logic              o_valid,
    output ktl_pkg::t_result  o_rd_data,
    output logic [ktl_pkg::FIFO_AW:0] o_count
);
    import ktl_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;
    logic [FIFO_AW-1:0]   n_wr_ptr1;
    logic                 pop;

    assign pop       = i_rd && (r_count != '0);
    assign n_wr_ptr1 = r_wr_ptr + FIFO_AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr_data0;
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[n_wr_ptr1] <= i_wr_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(i_wr_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + (FIFO_AW+1)'(i_wr_cnt) - (FIFO_AW+1)'(pop);
        end
    end

    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_count   = r_count;

endmodule

@@ hdl/keyword_token_lexer_top.sv @@
// Keyword token lexer: one-character lookahead tokeniser with a result queue.
// A result enters the queue in the cycle after the transaction that completes its token
// is accepted (a token waits for the next character unless the stream ends there).
// One character per cycle while the input is not stalled; a character that ends two tokens puts two
// results in the queue, and the output side drains one per cycle while i_out_stall is low.
// Input stalls while the queue count, plus two for a transaction in the input register,
// exceeds four. Reset (synchronous, active low) clears the lookahead, token state and queue.
module keyword_token_lexer_top #(
    parameter int MAX_TOKEN  = 35,
    parameter int PREFIX_LEN = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [4:0] o_token_kind,
    output logic [5:0] o_token_length,
    output logic       o_last_of_run
);
    import ktl_pkg::*;

    localparam int CW  = $clog2(MAX_TOKEN + 1);
    localparam int PIW = $clog2(PREFIX_LEN);

    typedef logic [PREFIX_LEN-1:0][7:0] t_prefix;

    typedef struct packed {
        logic [CW-1:0] count;
        logic          in_comment;
        logic          in_literal;
        logic          saw_tilde;
        logic          saw_quote;
    } t_tok;

    typedef struct packed {
        t_tok       st;
        t_prefix    pfx;
        logic       emit;
        logic [4:0] kind;
        logic [5:0] len;
    } t_take;

    function automatic t_take take_char(input t_tok s, input t_prefix p, input logic [7:0] c,
                                        input logic [7:0] nxt, input logic has_next);
        t_take r;
        logic  check;
        r.st  = s;
        r.pfx = p;
        if (32'(s.count) < PREFIX_LEN) begin
            r.pfx[s.count[PIW-1:0]] = c;
        end
        r.st.count = s.count + CW'(1);
        check = 1'b1;
        if (s.in_comment) begin
            check = (c == CH_TILDE);
            if (check) r.st.in_comment = 1'b0;
        end else if (s.in_literal) begin
            check = (c == CH_QUOTE);
            if (check) r.st.in_literal = 1'b0;
        end else if (c == CH_TILDE) begin
            r.st.in_comment = 1'b1;
            r.st.saw_tilde  = 1'b1;
            check           = 1'b0;
        end else if (c == CH_QUOTE) begin
            r.st.in_literal = 1'b1;
            r.st.saw_quote  = 1'b1;
            check           = 1'b0;
        end
        r.emit = (check && (is_cur_ender(c) || (has_next && is_next_ender(nxt)))) ||
                 (32'(r.st.count) >= MAX_TOKEN);
        r.kind = classify(t_kw_prefix'(r.pfx[KW_MAX_LEN-1:0]), 8'(r.st.count),
                          r.st.saw_tilde, r.st.saw_quote);
        r.len  = 6'(r.st.count);
        if (r.emit) begin
            r.st = '0;
        end
        return r;
    endfunction

    // input register
    logic          r_in_valid;
    logic [7:0]    r_in_char;
    logic          r_in_last;
    // token state
    t_tok          r_tok;
    t_prefix       r_pfx;
    logic [7:0]    r_pend_char;
    logic          r_pend_valid;

    t_tok          n_tok;
    t_prefix       n_pfx;
    logic [7:0]    n_pend_char;
    logic          n_pend_valid;

    t_take         take1;
    t_take         take2;
    t_tok          mid_tok;
    t_prefix       mid_pfx;
    logic          res_a;
    logic [1:0]    wr_cnt;
    t_result       wr_data0;
    t_result       wr_data1;
    t_result       rd_data;
    logic [FIFO_AW:0] q_count;
    logic          in_accept;

    assign in_accept = i_in_valid && !o_in_stall;
    // leave room for the transaction in flight and the new one, two results each
    assign o_in_stall = (32'(q_count) + (r_in_valid ? 2 : 0)) > (FIFO_DEPTH - 4);

    always_comb begin
        take1 = take_char(r_tok, r_pfx, r_pend_char, r_in_char, 1'b1);
        if (r_pend_valid) begin
            mid_tok = take1.st;
            mid_pfx = take1.pfx;
        end else begin
            mid_tok = r_tok;
            mid_pfx = r_pfx;
        end
        res_a = r_pend_valid && take1.emit;
        // final character: taken with no lookahead, then whatever is left is flushed
        take2 = take_char(mid_tok, mid_pfx, r_in_char, 8'h00, 1'b0);

        n_tok        = r_tok;
        n_pfx        = r_pfx;
        n_pend_char  = r_pend_char;
        n_pend_valid = r_pend_valid;
        wr_cnt       = 2'd0;
        wr_data0     = '0;
        wr_data1     = '0;
        if (r_in_valid) begin
            if (r_in_last) begin
                n_tok        = '0;
                n_pfx        = take2.pfx;
                n_pend_char  = 8'h00;
                n_pend_valid = 1'b0;
            end else begin
                n_tok        = mid_tok;
                n_pfx        = mid_pfx;
                n_pend_char  = r_in_char;
                n_pend_valid = 1'b1;
            end
            if (res_a && r_in_last) begin
                wr_cnt   = 2'd2;
                wr_data0 = '{kind: take1.kind, length: take1.len, last: 1'b0};
                wr_data1 = '{kind: take2.kind, length: take2.len, last: 1'b1};
            end else if (res_a) begin
                wr_cnt   = 2'd1;
                wr_data0 = '{kind: take1.kind, length: take1.len, last: 1'b1};
            end else if (r_in_last) begin
                wr_cnt   = 2'd1;
                wr_data0 = '{kind: take2.kind, length: take2.len, last: 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_tok        <= '0;
            r_pend_char  <= 8'h00;
            r_pend_valid <= 1'b0;
        end else begin
            r_in_valid   <= in_accept;
            r_tok        <= n_tok;
            r_pend_char  <= n_pend_char;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_char_in;
            r_in_last <= i_end_of_input;
        end
        r_pfx <= n_pfx;
    end

    ktl_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_cnt   (wr_cnt),
        .i_wr_data0 (wr_data0),
        .i_wr_data1 (wr_data1),
        .i_rd       (!i_out_stall),
        .o_valid    (o_out_valid),
        .o_rd_data  (rd_data),
        .o_count    (q_count)
    );

    assign o_token_kind   = rd_data.kind;
    assign o_token_length = rd_data.length;
    assign o_last_of_run  = rd_data.last;

endmodule
